FILE: rtl/core/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

FILE: rtl/core/sobel_pkg.sv
package sobel_pkg;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned CCOL_W = 10;
  localparam int unsigned OUT_W  = 48;

  localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

  // window centre bookkeeping carried alongside each pixel
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] col;
  } tag_t;

  // [row][column][bits], row 0 on top, column 2 newest
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  function automatic logic [7:0] sobel_band(input logic [7:0] t0, input logic [7:0] t1,
                                            input logic [7:0] t2, input logic [7:0] m0,
                                            input logic [7:0] m2, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2);
    logic [9:0]         top, bot, lft, rgt;
    logic signed [11:0] gy, gx, g;
    logic [7:0]         res;
    top = 10'(t0) + {1'b0, t1, 1'b0} + 10'(t2);
    bot = 10'(b0) + {1'b0, b1, 1'b0} + 10'(b2);
    lft = 10'(t0) + {1'b0, m0, 1'b0} + 10'(b0);
    rgt = 10'(t2) + {1'b0, m2, 1'b0} + 10'(b2);
    gy  = $signed({2'b00, top}) - $signed({2'b00, bot});
    gx  = $signed({2'b00, lft}) - $signed({2'b00, rgt});
    g   = (gy >= gx) ? gy : gx;
    if (g < 12'sd0) begin
      res = 8'd0;
    end else if (g > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = g[7:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/sobel_edge_rgb_max_combine_unit.sv
// Sobel edge filter on an RGB raster stream, max of vertical and horizontal
// gradient per colour band, clamped to 0..255.
// Input stream: one pixel per item, s_axis_tuser marks the first pixel of a
// frame. Results come only for interior pixels (row and column >= 1 and
// below the last), tagged with the centre row and column; tlast flags the
// frame's final interior pixel.
// Configuration: cfg_idx_i 0 is the image width, 1 the image height; write
// only while the stream is idle.
// Throughput: one item per cycle while results are taken. Accept to valid:
// line-memory read at accept, window update, gradient into output register.
// The two previous rows sit in one single-port-write line memory of
// MAX_WIDTH entries; the read-modify-write of a column is forwarded when
// the same column is hit by consecutive items.
// Reset clears counters, window and the output valid flag; size registers
// come up as 640 x 480. Line memory contents are not cleared.
// When the receiver stalls the whole pipeline holds and s_axis_tready drops
// until the pending result is taken.
module sobel_edge_rgb_max_combine_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // red_in, green_in, blue_in
  input  logic [0:0]                  s_axis_tuser,  // frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // red_out, green_out, blue_out, center_row, center_col, zero fill
  output logic [sobel_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,  // last_of_frame
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [sobel_pkg::CFG_W-1:0] cfg_data_i
);
  import sobel_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic             en, acc, win_vld;
  logic [COL_W-1:0] col;
  tag_t             tag, win_tag;
  win_t             win;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  sobel_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .acc_i        (acc),
    .frame_start_i(s_axis_tuser[0]),
    .col_o        (col),
    .tag_o        (tag)
  );

  sobel_lbuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_lbuf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .acc_i (acc),
    .col_i (col),
    .px_i  (s_axis_tdata),
    .tag_i (tag),
    .vld_o (win_vld),
    .tag_o (win_tag),
    .win_o (win)
  );

  sobel_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (win_vld),
    .tag_i   (win_tag),
    .win_i   (win),
    .tvalid_o(m_axis_tvalid),
    .tdata_o (m_axis_tdata),
    .tlast_o (m_axis_tlast)
  );

endmodule

FILE: rtl/core/sobel_ctrl.sv
`include "assert_macros.svh"

module sobel_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [sobel_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                           acc_i,
  input  logic                           frame_start_i,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_o,
  output sobel_pkg::tag_t                tag_o
);
  import sobel_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WC_W  = ((MW_W > WIDTH_W) ? MW_W : WIDTH_W) + 1;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [COL_W-1:0]    col_q, cur_col;
  logic [ROW_W-1:0]    row_q, cur_row;
  logic [WC_W-1:0]     w_raw, w_eff, col_nx;
  logic [HEIGHT_W-1:0] h_eff, row_nx;

  always_comb begin
    w_raw = WC_W'(width_q);
    if (w_raw < WC_W'(3)) begin
      w_eff = WC_W'(3);
    end else if (w_raw > WC_W'(MAX_WIDTH)) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_q < HEIGHT_W'(3)) begin
      h_eff = HEIGHT_W'(3);
    end else if (height_q > HEIGHT_W'(4096)) begin
      h_eff = HEIGHT_W'(4096);
    end else begin
      h_eff = height_q;
    end
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    col_nx  = WC_W'(cur_col) + WC_W'(1);
    row_nx  = HEIGHT_W'(cur_row) + HEIGHT_W'(1);
  end

  assign col_o     = cur_col;
  assign tag_o.emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
  assign tag_o.last = (cur_row == ROW_W'(h_eff - HEIGHT_W'(1)))
                    && (WC_W'(cur_col) == w_eff - WC_W'(1));
  assign tag_o.row  = cur_row - ROW_W'(1);
  assign tag_o.col  = CCOL_W'(cur_col - COL_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= WIDTH_W'(640);
      height_q <= HEIGHT_W'(480);
    end else begin
      if (acc_i) begin
        if (col_nx >= w_eff) begin
          col_q <= '0;
          row_q <= (row_nx >= h_eff) ? '0 : row_nx[ROW_W-1:0];
        end else begin
          col_q <= col_nx[COL_W-1:0];
          row_q <= cur_row;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          CFG_IDX_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // the frame's last pixel always sits on the interior
  `ASSERT_PROP(last_is_interior_a, clk_i, rst_ni, acc_i && tag_o.last |-> tag_o.emit,
               "last item of frame outside interior")
  `ASSERT_PROP(frame_restart_a, clk_i, rst_ni,
               acc_i && frame_start_i |=> (col_q == COL_W'(1)) && (row_q == '0),
               "frame start did not restart counters")

endmodule

FILE: rtl/core/sobel_lbuf.sv
`include "assert_macros.svh"

module sobel_lbuf #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  logic [sobel_pkg::PIX_W-1:0]  px_i,
  input  sobel_pkg::tag_t              tag_i,
  output logic                         vld_o,
  output sobel_pkg::tag_t              tag_o,
  output sobel_pkg::win_t              win_o
);
  import sobel_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // each entry holds {upper row, middle row} for one column
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q, fwd_data_q;
  logic               fwd_q, v1_q, v2_q;
  logic [COL_W-1:0]   col1_q;
  logic [PIX_W-1:0]   px1_q, up_eff, mid_eff;
  tag_t               tag1_q, tag2_q;
  win_t               win_q;

  // back-to-back items on the same column only after a frame restart
  assign {up_eff, mid_eff} = fwd_q ? fwd_data_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mem[col_i];
      if (v1_q) begin
        mem[col1_q] <= {mid_eff, px1_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col1_q     <= col_i;
      px1_q      <= px_i;
      tag1_q     <= tag_i;
      fwd_data_q <= {mid_eff, px1_q};
      tag2_q     <= tag1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      fwd_q <= 1'b0;
      win_q <= '0;
    end else if (en_i) begin
      v1_q  <= acc_i;
      fwd_q <= acc_i && v1_q && (col1_q == col_i);
      v2_q  <= v1_q && tag1_q.emit;
      if (v1_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= up_eff;
        win_q[1][2] <= mid_eff;
        win_q[2][2] <= px1_q;
      end
    end
  end

  assign vld_o = v2_q;
  assign tag_o = tag2_q;
  assign win_o = win_q;

  `ASSERT_PROP(fwd_needs_item_a, clk_i, rst_ni, fwd_q |-> v1_q,
               "forwarded line data without an item in the read stage")

endmodule

FILE: rtl/core/sobel_grad.sv
module sobel_grad (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  sobel_pkg::tag_t             tag_i,
  input  sobel_pkg::win_t             win_i,
  output logic                        tvalid_o,
  output logic [sobel_pkg::OUT_W-1:0] tdata_o,
  output logic                        tlast_o
);
  import sobel_pkg::*;

  logic [2:0][7:0]  band;
  logic             ov_q, last_q;
  logic [OUT_W-1:0] data_q;

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      band[b] = sobel_band(win_i[0][0][8*b +: 8], win_i[0][1][8*b +: 8],
                           win_i[0][2][8*b +: 8], win_i[1][0][8*b +: 8],
                           win_i[1][2][8*b +: 8], win_i[2][0][8*b +: 8],
                           win_i[2][1][8*b +: 8], win_i[2][2][8*b +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= {2'b0, tag_i.col, tag_i.row, band[2], band[1], band[0]};
      last_q <= tag_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_i) begin
      ov_q <= vld_i;
    end
  end

  assign tvalid_o = ov_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;

endmodule

FILE: tb/tb.sv
module tb;
  import sobel_pkg::*;

  localparam int unsigned LB_DEPTH       = 1024;
  localparam int unsigned MAX_ROWS       = 4096;
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;

  // red in the low byte, as on the stream
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct {
    rgb_t px;
    logic frame_start;
  } pixel_item_t;

  typedef struct {
    rgb_t              grad;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] col;
    logic              last;
  } edge_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // red_in, green_in, blue_in
  logic [0:0]          s_axis_tuser  = '0;  // frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // red, green, blue, center_row, center_col
  logic                m_axis_tlast;        // last_of_frame
  logic                cfg_we_i      = 1'b0;
  logic [0:0]          cfg_idx_i     = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]    cfg_data_i    = '0;

  sobel_edge_rgb_max_combine_unit #(
    .MAX_WIDTH(LB_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // filter state as the block should hold it
  rgb_t        lb_upper  [LB_DEPTH];
  rgb_t        lb_middle [LB_DEPTH];
  rgb_t        win [3][3] = '{default: '0};
  int unsigned row_cnt    = 0;
  int unsigned col_cnt    = 0;
  int unsigned cfg_width  = 640;
  int unsigned cfg_height = 480;

  pixel_item_t pix_q [$];
  edge_res_t   edge_q [$];
  rgb_t        smooth_px = '0;

  int unsigned n_pix    = 0;
  int unsigned n_res    = 0;
  int unsigned n_frames = 0;
  int unsigned n_cfg    = 0;
  int unsigned n_err    = 0;

  function automatic int unsigned eff_width(input int unsigned v);
    return (v < 3) ? 3 : ((v > LB_DEPTH) ? LB_DEPTH : v);
  endfunction

  function automatic logic [7:0] grad_band(input int unsigned b);
    int t0, t1, t2, m0, m2, b0, b1, b2, gy, gx, g;
    t0 = int'(win[0][0][8*b +: 8]);
    t1 = int'(win[0][1][8*b +: 8]);
    t2 = int'(win[0][2][8*b +: 8]);
    m0 = int'(win[1][0][8*b +: 8]);
    m2 = int'(win[1][2][8*b +: 8]);
    b0 = int'(win[2][0][8*b +: 8]);
    b1 = int'(win[2][1][8*b +: 8]);
    b2 = int'(win[2][2][8*b +: 8]);
    gy = t0 + 2 * t1 + t2 - b0 - 2 * b1 - b2;
    gx = t0 + 2 * m0 + b0 - t2 - 2 * m2 - b2;
    g  = (gy >= gx) ? gy : gx;
    if (g < 0) g = 0;
    if (g > 255) g = 255;
    return 8'(g);
  endfunction

  task automatic sobel_step(input pixel_item_t it);
    int unsigned w, h, c, y;
    edge_res_t   r;
    w = eff_width(cfg_width);
    h = (cfg_height < 3) ? 3 : ((cfg_height > MAX_ROWS) ? MAX_ROWS : cfg_height);
    if (it.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    c = col_cnt % LB_DEPTH;
    for (y = 0; y < 3; y++) begin
      win[y][0] = win[y][1];
      win[y][1] = win[y][2];
    end
    win[0][2] = lb_upper[c];
    win[1][2] = lb_middle[c];
    win[2][2] = it.px;
    lb_upper[c]  = lb_middle[c];
    lb_middle[c] = it.px;
    if (row_cnt >= 2 && col_cnt >= 2) begin
      r.grad.red   = grad_band(0);
      r.grad.green = grad_band(1);
      r.grad.blue  = grad_band(2);
      r.row        = ROW_W'(row_cnt - 1);
      r.col        = CCOL_W'(col_cnt - 1);
      r.last       = (row_cnt == h - 1) && (col_cnt == w - 1);
      edge_q.push_back(r);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  // per-item wait, with stretches of back-to-back items
  function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 80);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t: %s", $time, msg);
  endtask

  // sender
  int unsigned tx_gap = 0, tx_run = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk_i) begin : pixel_driver
    pixel_item_t acc, nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.px          = s_axis_tdata;
        acc.frame_start = s_axis_tuser[0];
        sobel_step(acc);
        n_pix++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pix_q.size() != 0) begin
          nxt = pix_q.pop_front();
          s_axis_tdata  <= nxt.px;
          s_axis_tuser  <= nxt.frame_start;
          s_axis_tvalid <= 1'b1;
          tx_gap        <= draw_wait(tx_run, tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int unsigned rx_wait = 0, rx_run = 0, hold_left = 0;
  bit          rx_calm = 1'b0, hold_done = 1'b0;

  always @(posedge clk_i) begin : result_sink
    int unsigned w;
    if (rst_ni) begin
      w = rx_wait;
      if (m_axis_tvalid && m_axis_tready) w = draw_wait(rx_run, rx_calm);
      else if (w != 0) w--;
      rx_wait       <= w;
      m_axis_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // one long back-pressure stretch so the pipeline fills and stalls its input
  always @(posedge clk_i) begin : long_hold
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_res == 120) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    edge_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.grad = m_axis_tdata[23:0];
      got.row  = m_axis_tdata[24 +: ROW_W];
      got.col  = m_axis_tdata[24 + ROW_W +: CCOL_W];
      got.last = m_axis_tlast;
      n_res <= n_res + 1;
      if (got.last) n_frames <= n_frames + 1;
      if (edge_q.size() == 0) begin
        flag_error($sformatf("unexpected result rgb %0d/%0d/%0d row %0d col %0d last %b",
                             got.grad.red, got.grad.green, got.grad.blue,
                             got.row, got.col, got.last));
      end else begin
        want = edge_q.pop_front();
        if (got.grad.red !== want.grad.red || got.grad.green !== want.grad.green ||
            got.grad.blue !== want.grad.blue || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          flag_error($sformatf({"expected rgb %0d/%0d/%0d row %0d col %0d last %b, ",
                                "got rgb %0d/%0d/%0d row %0d col %0d last %b"},
                               want.grad.red, want.grad.green, want.grad.blue,
                               want.row, want.col, want.last,
                               got.grad.red, got.grad.green, got.grad.blue,
                               got.row, got.col, got.last));
        end
      end
    end
  end

  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, edge_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_cfg(input logic [0:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_IDX_WIDTH) cfg_width = value % 2048;
    else cfg_height = value % 8192;
    n_cfg++;
  endtask

  // idle means nothing queued, nothing offered and nothing owed, plus pipeline drain
  task automatic wait_quiet();
    do @(negedge clk_i); while (pix_q.size() != 0 || s_axis_tvalid || edge_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic pixel_item_t rand_pixel(input bit fs, input bit strays);
    pixel_item_t it;
    int          b, v;
    for (b = 0; b < 3; b++) begin
      if ($urandom_range(0, 1)) begin
        v = $urandom_range(0, 255);
      end else begin
        // drift from the previous pixel so gradients land inside 0..255 too
        v = int'(smooth_px[8*b +: 8]) + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      smooth_px[8*b +: 8] = 8'(v);
    end
    it.px          = smooth_px;
    it.frame_start = fs || (strays && $urandom_range(0, 249) == 0);
    return it;
  endfunction

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned n,
                           input bit strays);
    int unsigned i;
    bit          grows;
    wait_quiet();
    // a wider row would read line memory never written, so restart the frame then
    grows = eff_width(w) > eff_width(cfg_width);
    write_cfg(CFG_IDX_WIDTH, w);
    write_cfg(CFG_IDX_HEIGHT, h);
    @(negedge clk_i);
    for (i = 0; i < n; i++) pix_q.push_back(rand_pixel(grows && i == 0, strays));
  endtask

  initial begin : stimulus
    int unsigned k, y, x, i;
    rgb_t        p;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three 3x3 frames: clamp high, a zero result, each gradient direction winning,
    // a mid-range value; later frames start by wrap-around, not by frame_start
    write_cfg(CFG_IDX_WIDTH, 3);
    write_cfg(CFG_IDX_HEIGHT, 3);
    @(negedge clk_i);
    for (k = 0; k < 3; k++) begin
      for (y = 0; y < 3; y++) begin
        for (x = 0; x < 3; x++) begin
          case (k)
            0: begin
              p.red   = (y == 0) ? 8'd255 : 8'd0;
              p.green = (y == 0) ? 8'd0 : 8'd255;
              p.blue  = (x == 0) ? 8'd255 : 8'd0;
            end
            1: begin
              p.red   = 8'(120 - 25 * int'(y) + 3 * int'(x));
              p.green = (x == 2) ? 8'd255 : 8'd0;
              p.blue  = (y == 1) ? 8'd255 : 8'd0;
            end
            default: begin
              p.red   = 8'd255;
              p.green = 8'd255;
              p.blue  = 8'(200 - 100 * int'(x));
            end
          endcase
          pix_q.push_back('{px: p, frame_start: (k == 0 && y == 0 && x == 0)});
        end
      end
    end

    run_phase(5, 4, 200, 1'b1);
    run_phase(1, 0, 100, 1'b1);      // both sizes below range
    run_phase(12, 7, 250, 1'b1);
    run_phase(6, 9, 200, 1'b1);      // shrink while mid-row
    run_phase(2, 5, 100, 1'b1);
    run_phase(20, 3, 180, 1'b1);
    run_phase(9, 8, 200, 1'b1);
    run_phase(2047, 0, 120, 1'b0);   // width above range, start of the widest row
    run_phase(12, 7, 100, 1'b1);     // column counter already past the new width
    run_phase(0, 8191, 150, 1'b0);   // height above range, top of the tallest frame
    run_phase(1024, 4096, 100, 1'b1);
    run_phase(7, 6, 150, 1'b1);

    while (pix_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    i = 0;
    while (edge_q.size() != 0 && i < 5000) begin
      @(negedge clk_i);
      i++;
    end
    repeat (10) @(negedge clk_i);
    if (edge_q.size() != 0) flag_error($sformatf("%0d results never arrived", edge_q.size()));

    $display("%0d pixels sent over %0d size writes, %0d filtered pixels checked",
             n_pix, n_cfg, n_res);
    $display("%0d frame ends flagged, %0d mismatches", n_frames, n_err);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sobel_edge_rgb_max_combine_unit.f
+incdir+rtl/core
rtl/core/sobel_pkg.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_lbuf.sv
rtl/core/sobel_grad.sv
rtl/core/sobel_edge_rgb_max_combine_unit.sv
tb/tb.sv
